>>> rtl/vad_pkg.sv
// Shared widths, sideband types and CORDIC constants for the vector angle pipeline.
package vad_pkg;

    localparam int SQ_W         = 64;
    localparam int ROOT_W       = 32;
    localparam int NORM_W       = 31;
    localparam int CX_W         = 64;
    localparam int Z_W          = 34;
    localparam int TURN_W       = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int PRE_SHIFT    = 26;
    localparam int PI_W         = 30;
    localparam logic [PI_W-1:0] PI_Q28 = 30'h3243F6A9;

    typedef struct packed {
        logic zero;
        logic dneg;
    } tag_t;

    function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
        logic [TURN_W-1:0] t;
        case (idx)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2FA;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            5'd24:   t = 32'h00000029;
            5'd25:   t = 32'h00000014;
            5'd26:   t = 32'h0000000A;
            5'd27:   t = 32'h00000005;
            5'd28:   t = 32'h00000003;
            5'd29:   t = 32'h00000001;
            5'd30:   t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/vad_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a passthrough sideband.
module vad_isqrt #(
    parameter int SIDE_W = 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [vad_pkg::SQ_W-1:0]      radicand,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [vad_pkg::ROOT_W-1:0]    root,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int STEPS = vad_pkg::ROOT_W;

    logic                     v_w    [0:STEPS];
    logic [vad_pkg::SQ_W-1:0] n_w    [0:STEPS];
    logic [vad_pkg::SQ_W-1:0] r_w    [0:STEPS];
    logic [SIDE_W-1:0]        side_w [0:STEPS];

    assign v_w[0]    = in_valid;
    assign n_w[0]    = radicand;
    assign r_w[0]    = '0;
    assign side_w[0] = in_side;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [vad_pkg::SQ_W-1:0] BIT = vad_pkg::SQ_W'(1) << (62 - 2 * k);

        logic                     v_reg;
        logic [vad_pkg::SQ_W-1:0] n_reg;
        logic [vad_pkg::SQ_W-1:0] r_reg;
        logic [SIDE_W-1:0]        side_reg;
        logic [vad_pkg::SQ_W-1:0] trial;
        logic                     take;
        logic [vad_pkg::SQ_W-1:0] n_next;
        logic [vad_pkg::SQ_W-1:0] r_next;

        always_comb
        begin
            trial  = r_w[k] + BIT;
            take   = n_w[k] >= trial;
            n_next = take ? n_w[k] - trial : n_w[k];
            r_next = take ? (r_w[k] >> 1) + BIT : r_w[k] >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg    <= n_next;
                r_reg    <= r_next;
                side_reg <= side_w[k];
            end
        end

        assign v_w[k+1]    = v_reg;
        assign n_w[k+1]    = n_reg;
        assign r_w[k+1]    = r_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = v_w[STEPS];
    assign root      = r_w[STEPS][vad_pkg::ROOT_W-1:0];
    assign out_side  = side_w[STEPS];

endmodule

>>> rtl/vad_cordic.sv
// Pipelined CORDIC vectoring run that accumulates the angle in turns, one step per stage.
module vad_cordic #(
    parameter int SIDE_W = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [vad_pkg::CX_W-1:0]  x0,
    input  logic signed [vad_pkg::CX_W-1:0]  y0,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic signed [vad_pkg::Z_W-1:0]   z,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int STEPS = vad_pkg::CORDIC_STEPS;

    logic                            v_w    [0:STEPS];
    logic signed [vad_pkg::CX_W-1:0] x_w    [0:STEPS];
    logic signed [vad_pkg::CX_W-1:0] y_w    [0:STEPS];
    logic signed [vad_pkg::Z_W-1:0]  z_w    [0:STEPS];
    logic [SIDE_W-1:0]               side_w [0:STEPS];

    assign v_w[0]    = in_valid;
    assign x_w[0]    = x0;
    assign y_w[0]    = y0;
    assign z_w[0]    = '0;
    assign side_w[0] = in_side;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [vad_pkg::Z_W-1:0] TURN =
            vad_pkg::Z_W'(vad_pkg::atan_turn(5'(i)));

        logic                            v_reg;
        logic signed [vad_pkg::CX_W-1:0] x_reg;
        logic signed [vad_pkg::CX_W-1:0] y_reg;
        logic signed [vad_pkg::Z_W-1:0]  z_reg;
        logic [SIDE_W-1:0]               side_reg;
        logic signed [vad_pkg::CX_W-1:0] dx;
        logic signed [vad_pkg::CX_W-1:0] dy;
        logic signed [vad_pkg::CX_W-1:0] x_next;
        logic signed [vad_pkg::CX_W-1:0] y_next;
        logic signed [vad_pkg::Z_W-1:0]  z_next;

        always_comb
        begin
            dx = y_w[i] >>> i;
            dy = x_w[i] >>> i;
            if (!y_w[i][vad_pkg::CX_W-1])
            begin
                x_next = x_w[i] + dx;
                y_next = y_w[i] - dy;
                z_next = z_w[i] + TURN;
            end
            else
            begin
                x_next = x_w[i] - dx;
                y_next = y_w[i] + dy;
                z_next = z_w[i] - TURN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                side_reg <= side_w[i];
            end
        end

        assign v_w[i+1]    = v_reg;
        assign x_w[i+1]    = x_reg;
        assign y_w[i+1]    = y_reg;
        assign z_w[i+1]    = z_reg;
        assign side_w[i+1] = side_reg;
    end

    assign out_valid = v_w[STEPS];
    assign z         = z_w[STEPS];
    assign out_side  = side_w[STEPS];

endmodule

>>> rtl/vector_angular_distance.sv
// Top level of the vector angle pipeline: products, normalization, root, CORDIC, radians.
//
//  channel  | dir | tdata (low bit first)                                   | tuser
//  s_axis   | in  | first_x, first_y, first_z, second_x, second_y, second_z | -
//  m_axis   | out | angle                                                   | zero_length
//
// m_axis_tvalid follows the accepting edge through 77 register stages: 9 front stages,
// 32 square root stages, 32 CORDIC stages, 3 radian stages and the output register.
// One transaction enters per cycle while the skid buffer is empty; the output register
// plus a one-entry skid buffer decouple the sides; the pipeline holds while it is full.
// Reset clears all valid bits; payload registers are not reset.
module vector_angular_distance #(
    parameter int COMPONENT_WIDTH = 24,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // angle, zero pad
    output logic [((ANGLE_FRAC_BITS+2+7)/8)*8-1:0]   m_axis_tdata,
    // zero_length
    output logic                                     m_axis_tuser
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int F      = ANGLE_FRAC_BITS;
    localparam int ANG_W  = F + 2;
    localparam int OUT_W  = ((ANG_W + 7) / 8) * 8;
    localparam int PW     = 2 * CW;
    localparam int SW     = 2 * CW + 1;
    localparam int MW     = 2 * CW;
    localparam int LW     = $clog2(MW + 1);
    localparam int NW     = vad_pkg::NORM_W;
    localparam int SQTW   = 2 * NW;
    localparam int PRODW  = 32 + vad_pkg::PI_W;
    localparam int SIDE_W = NW + 2;

    logic en;

    // S1: operands
    logic                 v1_reg;
    logic signed [CW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic                 zero1_reg;
    logic                 a_zero, b_zero;

    assign a_zero = (s_axis_tdata[CW-1:0] == '0) && (s_axis_tdata[2*CW-1:CW] == '0)
                    && (s_axis_tdata[3*CW-1:2*CW] == '0);
    assign b_zero = (s_axis_tdata[4*CW-1:3*CW] == '0) && (s_axis_tdata[5*CW-1:4*CW] == '0)
                    && (s_axis_tdata[6*CW-1:5*CW] == '0);

    // S2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_reg [0:8];
    logic                 zero2_reg;

    // S3: sums
    logic                 v3_reg;
    logic signed [SW-1:0] dot_reg, c0_reg, c1_reg, c2_reg;
    logic                 zero3_reg;

    // S4: magnitudes
    logic                 v4_reg;
    logic [MW-1:0]        mdot_reg, mc0_reg, mc1_reg, mc2_reg;
    vad_pkg::tag_t        tag4_reg;

    // S5: combined magnitude bits
    logic                 v5_reg;
    logic [MW-1:0]        m5dot_reg, m5c0_reg, m5c1_reg, m5c2_reg;
    logic [MW-1:0]        orv_reg;
    vad_pkg::tag_t        tag5_reg;

    // S6: bit length
    logic                 v6_reg;
    logic [MW-1:0]        m6dot_reg, m6c0_reg, m6c1_reg, m6c2_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        len_next;
    vad_pkg::tag_t        tag6_reg;

    // S7: normalized values
    logic                 v7_reg;
    logic [NW-1:0]        ndot_reg, nc0_reg, nc1_reg, nc2_reg;
    vad_pkg::tag_t        tag7_reg;

    // S8: squares
    logic                 v8_reg;
    logic [SQTW-1:0]      sq0_reg, sq1_reg, sq2_reg;
    logic [NW-1:0]        dot8_reg;
    vad_pkg::tag_t        tag8_reg;

    // S9: sum of squares
    logic                      v9_reg;
    logic [vad_pkg::SQ_W-1:0]  sq_reg;
    logic [NW-1:0]             dot9_reg;
    vad_pkg::tag_t             tag9_reg;

    always_comb
    begin
        len_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (orv_reg[i])
            begin
                len_next = LW'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg    <= s_axis_tdata[CW-1:0];
            ay_reg    <= s_axis_tdata[2*CW-1:CW];
            az_reg    <= s_axis_tdata[3*CW-1:2*CW];
            bx_reg    <= s_axis_tdata[4*CW-1:3*CW];
            by_reg    <= s_axis_tdata[5*CW-1:4*CW];
            bz_reg    <= s_axis_tdata[6*CW-1:5*CW];
            zero1_reg <= a_zero || b_zero;

            p_reg[0]  <= ax_reg * bx_reg;
            p_reg[1]  <= ay_reg * by_reg;
            p_reg[2]  <= az_reg * bz_reg;
            p_reg[3]  <= ay_reg * bz_reg;
            p_reg[4]  <= az_reg * by_reg;
            p_reg[5]  <= az_reg * bx_reg;
            p_reg[6]  <= ax_reg * bz_reg;
            p_reg[7]  <= ax_reg * by_reg;
            p_reg[8]  <= ay_reg * bx_reg;
            zero2_reg <= zero1_reg;

            dot_reg   <= SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]);
            c0_reg    <= SW'(p_reg[3]) - SW'(p_reg[4]);
            c1_reg    <= SW'(p_reg[5]) - SW'(p_reg[6]);
            c2_reg    <= SW'(p_reg[7]) - SW'(p_reg[8]);
            zero3_reg <= zero2_reg;

            mdot_reg      <= MW'(dot_reg[SW-1] ? -dot_reg : dot_reg);
            mc0_reg       <= MW'(c0_reg[SW-1] ? -c0_reg : c0_reg);
            mc1_reg       <= MW'(c1_reg[SW-1] ? -c1_reg : c1_reg);
            mc2_reg       <= MW'(c2_reg[SW-1] ? -c2_reg : c2_reg);
            tag4_reg.zero <= zero3_reg;
            tag4_reg.dneg <= dot_reg[SW-1];

            m5dot_reg <= mdot_reg;
            m5c0_reg  <= mc0_reg;
            m5c1_reg  <= mc1_reg;
            m5c2_reg  <= mc2_reg;
            orv_reg   <= mdot_reg | mc0_reg | mc1_reg | mc2_reg;
            tag5_reg  <= tag4_reg;

            m6dot_reg <= m5dot_reg;
            m6c0_reg  <= m5c0_reg;
            m6c1_reg  <= m5c1_reg;
            m6c2_reg  <= m5c2_reg;
            len_reg   <= len_next;
            tag6_reg  <= tag5_reg;

            ndot_reg  <= NW'({m6dot_reg, NW'(0)} >> len_reg);
            nc0_reg   <= NW'({m6c0_reg, NW'(0)} >> len_reg);
            nc1_reg   <= NW'({m6c1_reg, NW'(0)} >> len_reg);
            nc2_reg   <= NW'({m6c2_reg, NW'(0)} >> len_reg);
            tag7_reg  <= tag6_reg;

            sq0_reg   <= SQTW'(nc0_reg) * SQTW'(nc0_reg);
            sq1_reg   <= SQTW'(nc1_reg) * SQTW'(nc1_reg);
            sq2_reg   <= SQTW'(nc2_reg) * SQTW'(nc2_reg);
            dot8_reg  <= ndot_reg;
            tag8_reg  <= tag7_reg;

            sq_reg    <= vad_pkg::SQ_W'(sq0_reg) + vad_pkg::SQ_W'(sq1_reg)
                         + vad_pkg::SQ_W'(sq2_reg);
            dot9_reg  <= dot8_reg;
            tag9_reg  <= tag8_reg;
        end
    end

    // cross product length: square root of the sum of squares
    logic                         vs_valid;
    logic [vad_pkg::ROOT_W-1:0]   vs_root;
    logic [SIDE_W-1:0]            vs_side;
    logic [NW-1:0]                vs_dot;
    vad_pkg::tag_t                vs_tag;

    vad_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v9_reg),
        .radicand  (sq_reg),
        .in_side   ({tag9_reg, dot9_reg}),
        .out_valid (vs_valid),
        .root      (vs_root),
        .out_side  (vs_side)
    );

    assign vs_dot = vs_side[NW-1:0];
    assign vs_tag = vs_side[SIDE_W-1:NW];

    // angle in turns
    logic signed [vad_pkg::CX_W-1:0] cx0, cy0;
    logic                            vc_valid;
    logic signed [vad_pkg::Z_W-1:0]  vc_z;
    vad_pkg::tag_t                   vc_tag;

    assign cx0 = vad_pkg::CX_W'(vs_dot) << vad_pkg::PRE_SHIFT;
    assign cy0 = vad_pkg::CX_W'(vs_root) << vad_pkg::PRE_SHIFT;

    vad_cordic #(
        .SIDE_W ($bits(vad_pkg::tag_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs_valid),
        .x0        (cx0),
        .y0        (cy0),
        .in_side   (vs_tag),
        .out_valid (vc_valid),
        .z         (vc_z),
        .out_side  (vc_tag)
    );

    // Q1..Q3: quadrant, scale to radians, round
    localparam logic signed [vad_pkg::Z_W-1:0] Z_QUARTER = vad_pkg::Z_W'(1) << 30;
    localparam logic [31:0]                    Z_HALF    = 32'h8000_0000;
    localparam logic [63:0]                    ROUND_ADD = 64'(1) << (58 - F);

    logic               vq1_reg, vq2_reg, vq3_reg;
    logic [31:0]        zq_reg;
    logic [31:0]        zq_next;
    logic               zero_q1_reg, zero_q2_reg, zero_q3_reg;
    logic [PRODW-1:0]   prod_reg;
    logic [ANG_W-1:0]   ang_reg;
    logic [63:0]        rounded;

    always_comb
    begin
        if (vc_z[vad_pkg::Z_W-1])
        begin
            zq_next = '0;
        end
        else if (vc_z > Z_QUARTER)
        begin
            zq_next = 32'(Z_QUARTER);
        end
        else
        begin
            zq_next = 32'(vc_z);
        end
        if (vc_tag.dneg)
        begin
            zq_next = Z_HALF - zq_next;
        end
    end

    assign rounded = 64'(prod_reg) + ROUND_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq1_reg <= 1'b0;
            vq2_reg <= 1'b0;
            vq3_reg <= 1'b0;
        end
        else if (en)
        begin
            vq1_reg <= vc_valid;
            vq2_reg <= vq1_reg;
            vq3_reg <= vq2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zq_reg      <= zq_next;
            zero_q1_reg <= vc_tag.zero;
            prod_reg    <= PRODW'(zq_reg) * PRODW'(vad_pkg::PI_Q28);
            zero_q2_reg <= zero_q1_reg;
            ang_reg     <= zero_q2_reg ? '0 : ANG_W'(rounded >> (59 - F));
            zero_q3_reg <= zero_q2_reg;
        end
    end

    // output register and skid buffer
    logic              out_valid_reg;
    logic [ANG_W-1:0]  out_ang_reg;
    logic              out_zero_reg;
    logic              skid_valid_reg;
    logic [ANG_W-1:0]  skid_ang_reg;
    logic              skid_zero_reg;
    logic              out_free;

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= vq3_reg;
            end
        end
        else if (en && vq3_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_ang_reg  <= skid_ang_reg;
                out_zero_reg <= skid_zero_reg;
            end
            else
            begin
                out_ang_reg  <= ang_reg;
                out_zero_reg <= zero_q3_reg;
            end
        end
        else if (en && vq3_reg)
        begin
            skid_ang_reg  <= ang_reg;
            skid_zero_reg <= zero_q3_reg;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_ang_reg);
    assign m_axis_tuser  = out_zero_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a transaction while the output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("skid buffer dropped a transaction during a stall");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero-length transaction carries a nonzero angle");

endmodule
